// ===== rtl/cmaf_pkg.sv =====
// Package with the shared types and constants of the column mode axis finder.
package cmaf_pkg;

  localparam int MaxHeight = 512;
  localparam int MaxWidth  = 1024;
  localparam int IdxW      = $clog2(MaxHeight);
  localparam int CntW      = 10;

  localparam logic [31:0]     BlueColor   = 32'h0000_ffff;
  localparam logic [9:0]      MarginStart = 10'(MaxWidth - 8);
  localparam logic [CntW-1:0] CountMax    = '1;

  localparam logic [1:0] StNoChange = 2'd0;
  localparam logic [1:0] StFound    = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StRecolor  = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] pixel_color;
    logic [9:0]  column_index;
    logic        first_column;
    logic        final_column;
    logic        last_row;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  axis_column;
    logic [31:0] mode_color;
    logic [31:0] pixel_out;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic first_idx;
    logic read;
    logic next_idx;
    logic hit;
    logic alloc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic        recolor;
    logic        margin;
    logic        count_en;
    logic        empty;
    logic        match;
    logic        idx_end;
    logic        last;
    logic        out_free;
    logic [9:0]  used;
    logic [9:0]  rows;
  } sts_t;

endpackage

// ===== rtl/cmaf_ctrl.sv =====
// Controller state machine of the column mode axis finder.
module cmaf_ctrl import cmaf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_READ, S_CMP, S_ALLOC, S_EMIT} state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.first_idx = 1'b1;
        if (sts.recolor) state_nxt = S_EMIT;
        else if (sts.margin) state_nxt = S_IDLE;
        else if (sts.count_en) state_nxt = sts.empty ? S_ALLOC : S_READ;
        else state_nxt = sts.last ? S_EMIT : S_IDLE;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.hit   = 1'b1;
          state_nxt = sts.last ? S_EMIT : S_IDLE;
        end else if (sts.idx_end) begin
          cmd.alloc = 1'b1;
          state_nxt = sts.last ? S_EMIT : S_IDLE;
        end else begin
          cmd.next_idx = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/cmaf_datapath.sv =====
// Datapath of the column mode axis finder: histogram memories, mode tracking and result register.
module cmaf_datapath import cmaf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic [9:0] cfg_height,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic [31:0]     color_mem [MaxHeight];
  logic [CntW-1:0] count_mem [MaxHeight];

  in_item_t        item_r;
  logic [IdxW-1:0] idx_r;
  logic [31:0]     rd_color_r;
  logic [CntW-1:0] rd_count_r;
  logic [9:0]      used_r;
  logic [9:0]      rows_r;
  logic [31:0]     best_color_r;
  logic [CntW-1:0] best_count_r;
  logic [31:0]     ref_mode_r;
  logic            axis_found_r;
  logic [31:0]     found_color_r;
  logic            out_valid_r;
  out_item_t       out_r;

  logic [9:0]      height_lim;
  logic [CntW-1:0] new_count;
  logic [CntW-1:0] cand_count;
  logic            full;
  logic            better;
  out_item_t       out_nxt;

  always_comb begin
    height_lim = cfg_height;
    if (cfg_height == 10'd0) height_lim = 10'd1;
    else if (cfg_height > 10'(MaxHeight)) height_lim = 10'(MaxHeight);
  end

  assign full       = (used_r >= 10'(MaxHeight));
  assign new_count  = (rd_count_r < CountMax) ? rd_count_r + 1'b1 : rd_count_r;
  assign cand_count = cmd.hit ? new_count : CntW'(1);
  assign better     = (cand_count > best_count_r) ||
                      (cand_count == best_count_r && item_r.pixel_color < best_color_r);

  assign sts.recolor  = item_r.kind;
  assign sts.margin   = (item_r.column_index >= MarginStart);
  assign sts.count_en = (rows_r < height_lim);
  assign sts.empty    = (used_r == 10'd0);
  assign sts.match    = (rd_color_r == item_r.pixel_color);
  assign sts.idx_end  = (10'(idx_r) + 10'd1 == used_r);
  assign sts.last     = item_r.last_row;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.used     = used_r;
  assign sts.rows     = rows_r;

  always_comb begin
    out_nxt = '0;
    if (item_r.kind) begin
      out_nxt.status    = StRecolor;
      out_nxt.pixel_out = (axis_found_r && item_r.pixel_color == found_color_r) ?
                          BlueColor : item_r.pixel_color;
    end else begin
      out_nxt.mode_color = best_color_r;
      if (item_r.first_column) begin
        out_nxt.status = item_r.final_column ? StNotFound : StNoChange;
      end else if (axis_found_r) begin
        out_nxt.status = StNoChange;
      end else if (best_color_r != ref_mode_r) begin
        out_nxt.status      = StFound;
        out_nxt.axis_column = item_r.column_index;
      end else begin
        out_nxt.status = item_r.final_column ? StNotFound : StNoChange;
      end
    end
  end

  // Histogram storage; only entries below the fill count are ever read.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_color_r <= color_mem[idx_r];
      rd_count_r <= count_mem[idx_r];
    end
    if (cmd.hit) begin
      count_mem[idx_r] <= new_count;
    end else if (cmd.alloc && !full) begin
      color_mem[used_r[IdxW-1:0]] <= item_r.pixel_color;
      count_mem[used_r[IdxW-1:0]] <= CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.first_idx) idx_r <= '0;
    else if (cmd.next_idx) idx_r <= idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r        <= '0;
      rows_r        <= '0;
      best_color_r  <= '0;
      best_count_r  <= '0;
      ref_mode_r    <= '0;
      axis_found_r  <= 1'b0;
      found_color_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.hit || cmd.alloc) begin
        rows_r <= rows_r + 1'b1;
        if (cmd.alloc && !full) used_r <= used_r + 1'b1;
        if ((cmd.hit || !full) && better) begin
          best_count_r <= cand_count;
          best_color_r <= item_r.pixel_color;
        end
      end
      if (cmd.emit) begin
        out_r <= out_nxt;
        if (!item_r.kind) begin
          if (item_r.first_column) begin
            ref_mode_r    <= best_color_r;
            axis_found_r  <= 1'b0;
            found_color_r <= '0;
          end else if (!axis_found_r && best_color_r != ref_mode_r) begin
            axis_found_r  <= 1'b1;
            found_color_r <= best_color_r;
          end
          used_r       <= '0;
          rows_r       <= '0;
          best_color_r <= '0;
          best_count_r <= '0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/column_mode_axis_finder.sv =====
// Top level of the column mode axis finder: configuration register, controller and datapath.
// Each scan pixel is matched against the distinct colors of its column by walking the
// histogram memory one entry at a time, each entry with a read state and then a compare
// state. The walk stops at a match or when it runs out of entries (at most the distinct
// colors seen so far in that column, at most 512); a pixel whose column is still empty
// goes straight to allocation, and a pixel past the image height is not counted. A pixel
// that closes the column then emits its result, waiting while an earlier result still
// waits. Margin pixels are skipped; recolor pixels emit a result, with the same wait.
// Results sit in an output register, so the next transfer can be taken while a result still
// waits.
module column_mode_axis_finder import cmaf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata
);

  logic [9:0] height_r;
  cmd_t       cmd;
  sts_t       sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= 10'(MaxHeight);
    end else if (cfg_we) begin
      height_r <= cfg_wdata;
    end
  end

  cmaf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cmaf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cfg_height (height_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.used <= 10'(MaxHeight))
    else $error("histogram fill count out of range");

  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.rows <= 10'(MaxHeight))
    else $error("row counter out of range");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the column mode axis finder: column scans, axis search, recolor.
module testbench;
  import cmaf_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [9:0] cfg_wdata;

  column_mode_axis_finder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the block state.
  logic [9:0]  height_reg;
  logic [31:0] hist_color [MaxHeight];
  logic [9:0]  hist_count [MaxHeight];
  int          hist_used;
  logic [31:0] lead_color;
  logic [9:0]  lead_count;
  logic [31:0] ref_mode;
  logic        axis_seen;
  logic [31:0] axis_color;
  int          rows_in_col;

  out_item_t expected_q[$];
  int n_items, n_results, n_mismatch, n_found, n_recolor;
  int cycle_count;
  bit no_idle;
  int in_gap_left, out_stall_left;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_ready <= 1'b1;
      out_stall_left <= 0;
    end else if (out_stall_left > 0) begin
      out_stall_left <= out_stall_left - 1;
      out_ready <= (out_stall_left == 1);
    end else if ($urandom_range(0, 15) == 0) begin
      out_stall_left <= $urandom_range(1, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h", out_data);
      end else begin
        out_item_t e;
        e = expected_q.pop_front();
        if (e !== out_data) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp st=%0d ax=%0d mode=%h pix=%h, got st=%0d ax=%0d mode=%h pix=%h",
                     e.status, e.axis_column, e.mode_color, e.pixel_out,
                     out_data.status, out_data.axis_column, out_data.mode_color,
                     out_data.pixel_out);
        end
      end
    end
  end

  function automatic void clear_histogram();
    for (int i = 0; i < MaxHeight; i++) hist_count[i] = '0;
    hist_used = 0;
    lead_color = '0;
    lead_count = '0;
    rows_in_col = 0;
  endfunction

  function automatic void tally_color(logic [31:0] color);
    int i;
    for (i = 0; i < hist_used; i++)
      if (hist_color[i] == color) break;
    if (i == hist_used) begin
      if (hist_used >= MaxHeight) return;
      hist_color[i] = color;
      hist_count[i] = '0;
      hist_used++;
    end
    if (hist_count[i] != CountMax) hist_count[i]++;
    if (hist_count[i] > lead_count || (hist_count[i] == lead_count && color < lead_color)) begin
      lead_count = hist_count[i];
      lead_color = color;
    end
  endfunction

  // Works out the result of one accepted item, if any.
  function automatic void predict_item(in_item_t it);
    out_item_t r;
    int lim;
    r = '0;
    if (it.kind) begin
      r.status = StRecolor;
      r.pixel_out = (axis_seen && it.pixel_color == axis_color) ? BlueColor : it.pixel_color;
      expected_q.push_back(r);
      n_recolor++;
      return;
    end
    if (it.column_index >= MarginStart) return;
    lim = (height_reg == 0) ? 1 : (height_reg > MaxHeight ? MaxHeight : height_reg);
    if (rows_in_col < lim) begin
      tally_color(it.pixel_color);
      rows_in_col++;
    end
    if (!it.last_row) return;
    r.mode_color = lead_color;
    r.status = StNoChange;
    if (it.first_column) begin
      ref_mode = lead_color;
      axis_seen = 0;
      axis_color = '0;
      if (it.final_column) r.status = StNotFound;
    end else if (axis_seen) begin
      r.status = StNoChange;
    end else if (lead_color != ref_mode) begin
      axis_seen = 1;
      axis_color = lead_color;
      r.status = StFound;
      r.axis_column = it.column_index;
      n_found++;
    end else if (it.final_column) begin
      r.status = StNotFound;
    end
    clear_histogram();
    expected_q.push_back(r);
  endfunction

  // Valid stays high between back-to-back transfers; it drops only for an idle gap or a drain.
  task automatic send_item(in_item_t it);
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    n_items++;
  endtask

  task automatic drain_and_config(logic [9:0] h);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    height_reg = h;
  endtask

  function automatic logic [31:0] pick_color(int palette);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hffff_ffff;
      2: return 32'h0;
      3: return BlueColor;
      default: return 32'h100 + $urandom_range(0, palette - 1);
    endcase
  endfunction

  task automatic send_pixel(bit kind, logic [31:0] c, logic [9:0] col, bit f, bit fin, bit l);
    in_item_t it;
    it.kind = kind;
    it.pixel_color = c;
    it.column_index = col;
    it.first_column = f;
    it.final_column = fin;
    it.last_row = l;
    send_item(it);
  endtask

  // One full scan right to left, columns of the given height, then recolor pixels.
  task automatic scan_image(int ncols, int rows, int palette, int n_recolor_px);
    for (int c = ncols - 1; c >= 0; c--) begin
      for (int r = 0; r < rows; r++) begin
        logic [9:0] col;
        col = (c == 0) ? 10'd0 : 10'(c);
        if ($urandom_range(0, 40) == 0) col = 10'(MarginStart + $urandom_range(0, 7));
        send_pixel(0, pick_color(palette), col, c == ncols - 1, c == 0, r == rows - 1);
      end
    end
    for (int k = 0; k < n_recolor_px; k++)
      send_pixel(1, $urandom_range(0, 3) == 0 ? axis_color : pick_color(palette),
                 10'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic test_directed();
    // Recolor with no axis, then a reference column, an axis column and recolor of it.
    send_pixel(1, 32'h1234_5678, 10'd0, 0, 0, 0);
    send_pixel(0, 32'hffff_ffff, 10'd1015, 1, 1, 1);   // below MarginStart, so counted: closes a column
    send_pixel(0, 32'h0000_0005, 10'd2, 1, 0, 0);
    send_pixel(0, 32'h0000_0003, 10'd2, 1, 0, 1);       // tie goes to smaller color
    send_pixel(0, 32'hffff_ffff, 10'd1, 0, 0, 0);
    send_pixel(0, 32'hffff_ffff, 10'd1, 0, 0, 1);       // axis found
    send_pixel(0, 32'h0000_0000, 10'd1014, 0, 0, 1);    // search done
    send_pixel(0, 32'h0000_0000, 10'd0, 0, 1, 1);
    send_pixel(1, 32'hffff_ffff, 10'd0, 0, 0, 0);
    send_pixel(1, 32'hffff_fffe, 10'd1023, 1, 1, 1);
    // Single-column scan: reference and final together.
    send_pixel(0, 32'hAAAA_5555, 10'd0, 1, 1, 1);
    // Column with no change, then final with no change.
    send_pixel(0, 32'h5555_AAAA, 10'd3, 1, 0, 1);
    send_pixel(0, 32'h5555_AAAA, 10'd1, 0, 0, 1);
    send_pixel(0, 32'h5555_AAAA, 10'd0, 0, 1, 1);
  endtask

  task automatic test_rows_past_height();
    drain_and_config(10'd1);
    // Only the first row counts; the rest are dropped.
    send_pixel(0, 32'h7, 10'd5, 1, 0, 0);
    send_pixel(0, 32'h1, 10'd5, 1, 0, 0);
    send_pixel(0, 32'h1, 10'd5, 1, 0, 1);
    drain_and_config(10'd0);                            // clamps to one row
    send_pixel(0, 32'h9, 10'd4, 0, 0, 0);
    send_pixel(0, 32'h2, 10'd4, 0, 0, 1);
    drain_and_config(10'd1023);                         // clamps to the maximum
    scan_image(2, 3, 4, 2);
  endtask

  task automatic test_random_scans(int target);
    logic [9:0] heights [5] = '{10'd1, 10'd2, 10'd4, 10'd7, 10'd16};
    while (n_items < target) begin
      logic [9:0] h;
      int rows;
      h = heights[$urandom_range(0, 4)];
      drain_and_config(h);
      rows = $urandom_range(0, 3) == 0 ? int'(h) + $urandom_range(1, 3) : int'(h);
      scan_image($urandom_range(1, 9), rows, $urandom_range(1, 4), $urandom_range(0, 6));
    end
  endtask

  task automatic test_tall_column();
    // One full-height column with many distinct colors.
    drain_and_config(10'd512);
    for (int r = 0; r < 512; r++)
      send_pixel(0, r < 40 ? 32'($urandom()) : 32'h42, 10'd7, 1, 0, r == 511);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_wdata = '0;
    no_idle = 0;
    cycle_count = 0;
    n_items = 0; n_results = 0; n_mismatch = 0; n_found = 0; n_recolor = 0;
    height_reg = 10'd512;
    ref_mode = '0; axis_seen = 0; axis_color = '0;
    for (int i = 0; i < MaxHeight; i++) hist_color[i] = '0;
    clear_histogram();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_rows_past_height();
    test_tall_column();
    test_random_scans(1350);
    no_idle = 1;
    test_random_scans(1550);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    $display("covered %0d items, %0d results (%0d axis hits, %0d recolored pixels)",
             n_items, n_results, n_found, n_recolor);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("status: fail");
    end
    $finish;
  end

endmodule
